// File: sv/ole_pkg.sv
package ole_pkg;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  typedef logic [ACTION_W-1:0]       action_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [STATUS_W-1:0]       status_t;

  localparam action_t ACT_INSERT = 3'd0;
  localparam action_t ACT_DELETE = 3'd1;
  localparam action_t ACT_READ   = 3'd2;
  localparam action_t ACT_SEARCH = 3'd3;
  localparam action_t ACT_CLEAR  = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

// File: sv/ole_intf.sv
interface ole_req_if;
  import ole_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  pos_t    position;
  value_t  value;

  modport source (output valid, output action, output position, output value, input ready);
  modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface ole_rsp_if;
  import ole_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  value_t  value_out;
  pos_t    found_position;
  pos_t    count;
  logic    empty_res;

  modport source (output valid, output status, output value_out, output found_position,
                  output count, output empty_res, input ready);
  modport sink   (input valid, input status, input value_out, input found_position,
                  input count, input empty_res, output ready);
endinterface

// File: sv/ordered_list_engine.sv
// Ordered list of signed 32-bit words held in one LIST_DEPTH-entry RAM (one write and one
// registered read port) plus an entry count. One request is processed at a time; the
// request channel reopens as soon as the result is staged, so the next request may be
// taken while the previous result waits in the output register. The RAM moves one entry per
// cycle: insert and delete shift the entries from position p on, search reads from the first
// entry until a match or the list end; read, clear and rejected requests move no entries.
// The RAM needs no clearing after reset; entries beyond the count may be read, but their data is never used.
module ordered_list_engine #(
  parameter int LIST_DEPTH = 128
) (
  input  logic      clk,
  input  logic      rst,
  ole_req_if.sink   req,
  ole_rsp_if.source rsp
);
  import ole_pkg::*;

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SHIFT_UP  = 3'd1;
  localparam logic [2:0] S_WRITE_NEW = 3'd2;
  localparam logic [2:0] S_DEL_FIRST = 3'd3;
  localparam logic [2:0] S_SHIFT_DN  = 3'd4;
  localparam logic [2:0] S_READ_WAIT = 3'd5;
  localparam logic [2:0] S_SEARCH    = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [AW-1:0] addr;
  logic [AW-1:0] tgt;
  value_t        val_q;
  status_t       status_q;
  value_t        vout_q;
  pos_t          found_q;

  logic          o_valid;
  status_t       o_status;
  value_t        o_vout;
  pos_t          o_found;
  pos_t          o_count;
  logic          o_empty;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [AW-1:0] pos_m1;
  logic [AW-1:0] last;
  logic          full;
  logic          bad_ins;
  logic          bad_pos;

  assign pos_x   = XW'(req.position);
  assign cnt_x   = XW'(count);
  assign pos_m1  = AW'(pos_x - XW'(1));
  assign last    = AW'(count - CW'(1));
  assign full    = cnt_x >= XW'(LIST_DEPTH);
  assign bad_ins = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
  assign bad_pos = (pos_x == '0) || (pos_x > cnt_x);

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = o_valid;
  assign rsp.status         = o_status;
  assign rsp.value_out      = o_vout;
  assign rsp.found_position = o_found;
  assign rsp.count          = o_count;
  assign rsp.empty_res      = o_empty;

  ole_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr + AW'(1);
    ram_wdata = ram_rdata;
    ram_raddr = addr + AW'(1);
    unique case (state)
      S_IDLE: begin
        priority if (req.action == ACT_INSERT) begin
          ram_raddr = last;
        end else if (req.action == ACT_SEARCH) begin
          ram_raddr = '0;
        end else begin
          ram_raddr = pos_m1;
        end
      end
      S_SHIFT_UP: begin
        ram_we    = 1'b1;
        ram_raddr = addr - AW'(1);
      end
      S_WRITE_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = tgt;
        ram_wdata = val_q;
      end
      S_SHIFT_DN: begin
        ram_we    = 1'b1;
        ram_waddr = addr - AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      o_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!o_valid || rsp.ready)) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            val_q    <= req.value;
            status_q <= ST_OK;
            vout_q   <= '0;
            found_q  <= '0;
            tgt      <= pos_m1;
            state    <= S_DONE;
            unique case (req.action)
              ACT_INSERT: begin
                priority if (full) begin
                  status_q <= ST_FULL;
                end else if (bad_ins) begin
                  status_q <= ST_RANGE;
                end else if (pos_x == cnt_x + XW'(1)) begin
                  state <= S_WRITE_NEW;
                end else begin
                  addr  <= last;
                  state <= S_SHIFT_UP;
                end
              end
              ACT_DELETE: begin
                if (bad_pos) begin
                  status_q <= ST_RANGE;
                end else begin
                  addr  <= pos_m1;
                  state <= S_DEL_FIRST;
                end
              end
              ACT_READ: begin
                if (bad_pos) begin
                  status_q <= ST_RANGE;
                end else begin
                  state <= S_READ_WAIT;
                end
              end
              ACT_SEARCH: begin
                if (count != '0) begin
                  addr  <= '0;
                  state <= S_SEARCH;
                end
              end
              ACT_CLEAR: begin
                count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SHIFT_UP: begin
          if (addr == tgt) begin
            state <= S_WRITE_NEW;
          end else begin
            addr <= addr - AW'(1);
          end
        end
        S_WRITE_NEW: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_DEL_FIRST: begin
          vout_q <= ram_rdata;
          if (addr == last) begin
            count <= count - CW'(1);
            state <= S_DONE;
          end else begin
            addr  <= addr + AW'(1);
            state <= S_SHIFT_DN;
          end
        end
        S_SHIFT_DN: begin
          if (addr == last) begin
            count <= count - CW'(1);
            state <= S_DONE;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        S_READ_WAIT: begin
          vout_q <= ram_rdata;
          state  <= S_DONE;
        end
        S_SEARCH: begin
          priority if (ram_rdata == val_q) begin
            found_q <= POS_W'(XW'(addr) + XW'(1));
            state   <= S_DONE;
          end else if (addr == last) begin
            state <= S_DONE;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        S_DONE: begin
          if (!o_valid || rsp.ready) begin
            o_status <= status_q;
            o_vout   <= vout_q;
            o_found  <= found_q;
            o_count  <= POS_W'(count);
            o_empty  <= (count == '0);
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(count) <= XW'(LIST_DEPTH))
    else $error("entry count beyond list depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && status_q == ST_FULL) |-> (XW'(count) == XW'(LIST_DEPTH)))
    else $error("full status with room left");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_SHIFT_UP || state == S_SHIFT_DN || state == S_WRITE_NEW))
    else $error("store written outside a shift or insert");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE || state == S_READ_WAIT || state == S_SEARCH) |=> $stable(count))
    else $error("count changed outside an update");

endmodule

// File: sv/ole_ram.sv
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/sv/tb_ordered_list_engine.sv
`timescale 1ns / 1ps

module tb_ordered_list_engine;
  import ole_pkg::*;

  localparam int LIST_DEPTH = 128;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_TAIL = 150;
  localparam int LONG_HOLD = 600;
  localparam value_t VAL_MIN = 32'sh8000_0000;
  localparam value_t VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    action_t action;
    pos_t    position;
    value_t  value;
    bit      drain;
  } list_req_t;

  typedef struct packed {
    status_t status;
    value_t  value_out;
    pos_t    found_position;
    pos_t    count;
    logic    empty_res;
  } list_result_t;

  logic clk = 1'b0;
  logic rst;

  ole_req_if req_if ();
  ole_rsp_if rsp_if ();

  ordered_list_engine #(.LIST_DEPTH(LIST_DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  always #5 clk = ~clk;

  value_t       list_mem [0:LIST_DEPTH-1];
  int           list_len = 0;
  list_req_t    req_backlog [$];
  list_result_t due_results [$];
  int           gen_len = 0;
  bit           drain_next = 1'b0;
  int           n_total = 0;
  int           n_sent = 0;
  int           n_accepted = 0;
  int           n_fail = 0;
  int           src_gap = 0;
  int           sink_hold = 0;
  bit           long_hold_done = 1'b0;
  value_t       value_pool [0:7] = '{VAL_MIN, VAL_MAX, -1, 0, 1, 2, 42, -42};

  function automatic list_result_t list_apply(action_t a, pos_t p, value_t v);
    list_result_t r;
    int k;
    int pi;
    r = '{ST_OK, '0, '0, '0, 1'b0};
    pi = p;
    case (a)
      ACT_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else if (pi < 1 || pi > list_len + 1) begin
          r.status = ST_RANGE;
        end else begin
          for (k = list_len; k >= pi; k--) list_mem[k] = list_mem[k-1];
          list_mem[pi-1] = v;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (pi < 1 || pi > list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.value_out = list_mem[pi-1];
          for (k = pi; k < list_len; k++) list_mem[k-1] = list_mem[k];
          list_len--;
        end
      end
      ACT_READ: begin
        if (pi < 1 || pi > list_len) r.status = ST_RANGE;
        else r.value_out = list_mem[pi-1];
      end
      ACT_SEARCH: begin
        for (k = 0; k < list_len; k++) begin
          if (list_mem[k] == v) begin
            r.found_position = pos_t'(k + 1);
            break;
          end
        end
      end
      ACT_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    r.count = pos_t'(list_len);
    r.empty_res = (list_len == 0);
    return r;
  endfunction

  function automatic void push_req(action_t a, int p, value_t v);
    list_req_t item;
    item.action = a;
    item.position = pos_t'(p);
    item.value = v;
    item.drain = drain_next;
    drain_next = 1'b0;
    req_backlog.push_back(item);
    case (a)
      ACT_INSERT: if (gen_len < LIST_DEPTH && p >= 1 && p <= gen_len + 1) gen_len++;
      ACT_DELETE: if (p >= 1 && p <= gen_len) gen_len--;
      ACT_CLEAR: gen_len = 0;
      default: begin
      end
    endcase
  endfunction

  function automatic value_t pick_value();
    if ($urandom_range(0, 2) == 0) return value_t'($urandom);
    return value_pool[$urandom_range(0, 7)];
  endfunction

  function automatic void push_noise();
    push_req(action_t'($urandom_range(0, 2**ACTION_W - 1)), $urandom_range(0, 255),
             value_t'($urandom));
  endfunction

  task automatic gen_fill();
    drain_next = ($urandom_range(0, 2) == 0);
    while (gen_len < LIST_DEPTH) push_req(ACT_INSERT, $urandom_range(gen_len + 1, 1), pick_value());
    repeat ($urandom_range(2, 4)) push_req(ACT_INSERT, $urandom_range(0, 255), pick_value());
    push_req(ACT_READ, LIST_DEPTH, 0);
    push_req(ACT_READ, LIST_DEPTH + 1, 0);
    repeat (3) push_req(ACT_SEARCH, 0, pick_value());
    repeat ($urandom_range(8, 40)) push_req(ACT_DELETE, $urandom_range(gen_len, 1), 0);
  endtask

  task automatic gen_mix(int n);
    int r;
    if ($urandom_range(0, 9) == 0) drain_next = 1'b1;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        if (gen_len < LIST_DEPTH) push_req(ACT_INSERT, $urandom_range(gen_len + 1, 1), pick_value());
        else push_noise();
      end else if (r < 55) begin
        if (gen_len > 0) push_req(ACT_DELETE, $urandom_range(gen_len, 1), pick_value());
        else push_req(ACT_DELETE, $urandom_range(0, 2), 0);
      end else if (r < 70) begin
        if (gen_len > 0) push_req(ACT_READ, $urandom_range(gen_len, 1), pick_value());
        else push_req(ACT_READ, 0, 0);
      end else if (r < 85) begin
        push_req(ACT_SEARCH, $urandom_range(0, 255), pick_value());
      end else if (r < 97) begin
        push_noise();
      end else begin
        push_req(ACT_CLEAR, $urandom_range(0, 255), value_t'($urandom));
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h actual 0x%0h", $time, name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        due_results.push_back(list_apply(req_if.action, req_if.position, req_if.value));
        n_accepted++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected transaction: expected none actual status %0d count %0d",
                   $time, rsp_if.status, rsp_if.count);
          n_fail++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, rsp_if.status);
          check_field("value_out", want.value_out, rsp_if.value_out);
          check_field("found_position", want.found_position, rsp_if.found_position);
          check_field("count", want.count, rsp_if.count);
          check_field("empty_res", want.empty_res, rsp_if.empty_res);
        end
      end
    end
  end

  always @(negedge clk) begin
    list_req_t nxt;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && n_sent != n_accepted) begin
      // hold until accepted
    end else if (src_gap > 0) begin
      src_gap--;
      req_if.valid <= 1'b0;
    end else if (req_backlog.size() != 0 &&
                 !(req_backlog[0].drain && due_results.size() != 0)) begin
      nxt = req_backlog.pop_front();
      req_if.action <= nxt.action;
      req_if.position <= nxt.position;
      req_if.value <= nxt.value;
      req_if.valid <= 1'b1;
      n_sent++;
      if (n_sent + CALM_TAIL < n_total && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 16);
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (!long_hold_done && n_accepted >= 300) begin
        long_hold_done = 1'b1;
        sink_hold = LONG_HOLD;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (n_sent + CALM_TAIL < n_total && $urandom_range(0, 7) == 0)
          sink_hold = $urandom_range(1, 16);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("ordered_list_engine regression: fail");
    $finish;
  end

  initial begin
    int phase;
    int a;
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.action = ACT_INSERT;
    req_if.position = '0;
    req_if.value = '0;
    rsp_if.ready = 1'b0;

    push_req(ACT_READ, 1, 0);
    push_req(ACT_DELETE, 0, 0);
    push_req(ACT_SEARCH, 0, 0);
    push_req(ACT_INSERT, 0, 7);
    push_req(ACT_INSERT, 2, 7);
    push_req(ACT_INSERT, 1, VAL_MAX);
    push_req(ACT_INSERT, 1, VAL_MIN);
    push_req(ACT_INSERT, 3, -1);
    push_req(ACT_INSERT, 2, 0);
    push_req(ACT_INSERT, 255, 5);
    push_req(ACT_READ, 1, 0);
    push_req(ACT_READ, 4, 0);
    push_req(ACT_READ, 5, 0);
    push_req(ACT_READ, 0, 0);
    push_req(ACT_SEARCH, 0, -1);
    push_req(ACT_SEARCH, 0, 32'sh1234_5678);
    push_req(ACT_INSERT, 5, VAL_MAX);
    push_req(ACT_SEARCH, 0, VAL_MAX);
    push_req(ACT_DELETE, 1, 0);
    push_req(ACT_DELETE, 4, 0);
    push_req(ACT_DELETE, 2, 0);
    for (a = ACT_CLEAR + 1; a < 2**ACTION_W; a++) push_req(action_t'(a), 255, -1);
    push_req(ACT_CLEAR, 0, 0);
    push_req(ACT_READ, 1, 0);
    push_req(ACT_DELETE, 1, 0);

    drain_next = 1'b1;
    phase = 0;
    while (req_backlog.size() < RANDOM_ITEMS + 27) begin
      phase++;
      if (phase % 6 == 2) gen_fill();
      else gen_mix($urandom_range(30, 60));
    end
    n_total = req_backlog.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (n_accepted == n_total);
    while (due_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (n_fail == 0) begin
      $display("ordered_list_engine regression: pass");
    end else begin
      $display("ordered_list_engine regression: fail");
    end
    $finish;
  end

endmodule

// File: ordered_list_engine.f
sv/ole_pkg.sv
sv/ole_intf.sv
sv/ole_ram.sv
sv/ordered_list_engine.sv
tb/sv/tb_ordered_list_engine.sv
